// File: src/ptfsm_pkg.sv
// Shared types and constants of the programmable table state machine.
// Holds item field widths, action codes and the sequencer state type.
// No dependencies.
package ptfsm_pkg;

	localparam int STATE_W  = 4;
	localparam int TRANS_W  = 4;
	localparam int GUARD_W  = 16;
	localparam int ACTION_W = 2;

	// States and transitions that the 4-bit item fields can name
	localparam int FIELD_STATES = 2 ** STATE_W;
	localparam int FIELD_TRANS  = 2 ** TRANS_W;

	localparam int DEF_MAX_STATES      = 16;
	localparam int DEF_MAX_TRANSITIONS = 16;

	typedef enum logic [ACTION_W-1:0] {
		ACT_STEP  = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_SET   = 2'd2,
		ACT_FORCE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAP,
		ST_NEXT
	} seq_state_t;

endpackage

// File: src/ptfsm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read during a write to the same address returns the old contents.
// No dependencies.
module ptfsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/programmable_table_fsm.sv
// Programmable table-driven state machine: top level.
// Depends on ptfsm_pkg and ptfsm_ram (row map RAM and next-state RAM).
//
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata with the action code in
//   s_tuser. Each input word yields exactly one result word on
//   m_tvalid/m_tready/m_tdata: current state, moved flag, fired transition.
//   Actions: step with guards, add a table entry, set the state, force one
//   transition. Table entries are added at run time; a step fires the lowest
//   listed transition of the current state whose guard bit is set.
//
// Timing:
//   The accepting cycle reads the state's row of listed marks.
//   The row stage then finishes add, set and a miss, or reads the next-state
//   RAM on a hit; the next-state stage finishes a hit. The next word is taken
//   in the finishing cycle, so a new word can enter while the last one
//   finishes; moves pass through both stages because of the two dependent
//   RAM reads. The result goes into a registered output.
//
// Reset clears the current state and all row valid marks; the table is empty.
// If the receiver stalls with a result pending, the finishing word waits in
// its stage and s_tready drops until the output register frees up.
module programmable_table_fsm
	import ptfsm_pkg::*;
#(
	parameter int MAX_STATES      = DEF_MAX_STATES,
	parameter int MAX_TRANSITIONS = DEF_MAX_TRANSITIONS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// guards[15:0], from_state[19:16], transition_number[23:20], to_state[27:24]
	input  logic [31:0] s_tdata,
	// action[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// state_now[3:0], moved[4], fired_transition[8:5]
	output logic [15:0] m_tdata
);

	localparam int NS = (MAX_STATES < FIELD_STATES) ? MAX_STATES : FIELD_STATES;
	localparam int NT = (MAX_TRANSITIONS < FIELD_TRANS) ? MAX_TRANSITIONS : FIELD_TRANS;
	localparam int SW = $clog2(NS);
	localparam int TW = (NT > 1) ? $clog2(NT) : 1;
	localparam int AW = $clog2(NS * NT);

	seq_state_t state_q, state_d;

	// item registers
	action_t             act_s1;
	logic [GUARD_W-1:0]  guards_s1;
	logic [STATE_W-1:0]  from_s1;
	logic [TRANS_W-1:0]  tr_s1;
	logic [STATE_W-1:0]  to_s1;
	logic [TW-1:0]       t_s2;

	logic [SW-1:0]       current_q;
	logic [NS-1:0]       valid_q;
	logic                fwd_hit_q;
	logic [NT-1:0]       fwd_row_q;
	logic [15:0]         out_q;
	logic                out_valid_q;

	// RAM ports
	logic                map_we, map_re;
	logic [SW-1:0]       map_waddr, map_raddr;
	logic [NT-1:0]       map_wdata, map_rdata;
	logic                nt_we, nt_re;
	logic [AW-1:0]       nt_waddr, nt_raddr;
	logic [SW-1:0]       nt_wdata, nt_rdata;

	logic                accept, out_free, done;
	logic [NT-1:0]       row, masked, hits;
	logic                found, tr_ok, listed;
	logic [TW-1:0]       t_sel, t_hit;
	logic                add_ok;
	logic [SW-1:0]       cur_next, cur_fwd;
	logic                moved_d;
	logic [TW-1:0]       fired_d;

	function automatic logic [AW-1:0] nt_addr(input logic [SW-1:0] st, input logic [TW-1:0] t);
		nt_addr = AW'(st) * AW'(NT) + AW'(t);
	endfunction

	ptfsm_ram #(.WIDTH(NT), .DEPTH(NS)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.re    (map_re),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	ptfsm_ram #(.WIDTH(SW), .DEPTH(NS * NT)) u_next_ram (
		.clk   (clk),
		.we    (nt_we),
		.waddr (nt_waddr),
		.wdata (nt_wdata),
		.re    (nt_re),
		.raddr (nt_raddr),
		.rdata (nt_rdata)
	);

	// row of listed marks; bypass a write issued in the read cycle
	always_comb begin
		row    = fwd_hit_q ? fwd_row_q : map_rdata;
		masked = valid_q[current_q] ? row : '0;
		if (act_s1 == ACT_ADD) begin
			masked = valid_q[from_s1[SW-1:0]] ? row : '0;
		end
		hits  = masked & guards_s1[NT-1:0];
		found = 1'b0;
		t_sel = '0;
		for (int i = NT - 1; i >= 0; i--) begin
			if (hits[i]) begin
				found = 1'b1;
				t_sel = TW'(i);
			end
		end
		tr_ok  = (tr_s1 < NT);
		listed = tr_ok && masked[tr_s1[TW-1:0]];
		add_ok = (from_s1 < NS) && (to_s1 < NS) && tr_ok;
	end

	assign out_free = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d   = state_q;
		done      = 1'b0;
		cur_next  = current_q;
		moved_d   = 1'b0;
		fired_d   = '0;
		t_hit     = t_sel;
		nt_re     = 1'b0;
		nt_raddr  = nt_addr(current_q, t_sel);
		map_we    = 1'b0;
		map_waddr = from_s1[SW-1:0];
		map_wdata = masked | (NT'(1) << tr_s1[TW-1:0]);
		nt_we     = 1'b0;
		nt_waddr  = nt_addr(from_s1[SW-1:0], tr_s1[TW-1:0]);
		nt_wdata  = to_s1[SW-1:0];
		case (state_q)
			ST_IDLE: begin
			end
			ST_MAP: begin
				if (act_s1 == ACT_FORCE) begin
					t_hit = tr_s1[TW-1:0];
				end
				if ((act_s1 == ACT_STEP && found) || (act_s1 == ACT_FORCE && listed)) begin
					nt_re    = 1'b1;
					nt_raddr = nt_addr(current_q, t_hit);
					state_d  = ST_NEXT;
				end else begin
					done = out_free;
					if (act_s1 == ACT_SET && from_s1 < NS) begin
						cur_next = from_s1[SW-1:0];
					end
					if (done && act_s1 == ACT_ADD && add_ok) begin
						map_we = 1'b1;
						nt_we  = 1'b1;
					end
				end
			end
			ST_NEXT: begin
				done     = out_free;
				cur_next = nt_rdata;
				moved_d  = 1'b1;
				fired_d  = t_s2;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (done) begin
			state_d = ST_IDLE;
		end
		if (accept) begin
			state_d = ST_MAP;
		end
		s_tready = (state_q == ST_IDLE) || done;
	end

	// forward the state that this cycle's finishing word leaves behind
	assign cur_fwd   = done ? cur_next : current_q;
	assign map_re    = accept;
	assign map_raddr = (action_t'(s_tuser) == ACT_ADD) ? s_tdata[16 +: SW] : cur_fwd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			current_q   <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			fwd_hit_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (done) begin
				current_q <= cur_next;
			end
			if (map_we) begin
				valid_q[map_waddr] <= 1'b1;
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (map_re) begin
				fwd_hit_q <= map_we && (map_waddr == map_raddr);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1    <= action_t'(s_tuser);
			guards_s1 <= s_tdata[15:0];
			from_s1   <= s_tdata[19:16];
			tr_s1     <= s_tdata[23:20];
			to_s1     <= s_tdata[27:24];
		end
		if (map_re) begin
			fwd_row_q <= map_wdata;
		end
		if (nt_re) begin
			t_s2 <= t_hit;
		end
		if (done) begin
			out_q <= {7'd0, 4'(fired_d), moved_d, 4'(cur_next)};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	a_accept_to_map: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_MAP)
		else $error("accepted word did not enter the row read stage");

	a_next_after_map: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_NEXT |-> ($past(state_q) == ST_MAP || $past(state_q) == ST_NEXT))
		else $error("next-state stage entered without a row read");

	a_row_marked: assert property (@(posedge clk) disable iff (!arst_n)
		map_we |=> valid_q[$past(map_waddr)])
		else $error("written row not marked valid");

	a_no_move_no_fire: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[4]) |-> m_tdata[8:5] == 4'd0)
		else $error("fired transition nonzero without a move");

	a_done_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == ST_MAP || state_q == ST_NEXT))
		else $error("result finished outside a work stage");

endmodule
